>>> src/hcpm_pkg.sv
// Shared types, constants and helpers for the Hilbert curve point mapper.
package hcpm_pkg;

  localparam int unsigned ORDER_MAX = 16;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned LVL_W     = 5;
  localparam int unsigned IDX_W     = 2 * ORDER_MAX + 1;
  localparam int unsigned AIDX_W    = 2 * ORDER_MAX;
  localparam int unsigned SHAMT_W   = 6;
  localparam int unsigned FRAC_BITS = 17;
  localparam int unsigned CW        = FRAC_BITS + 2;
  localparam int unsigned POS_W     = 25;
  localparam int unsigned SCL_W     = POS_W + 1;
  localparam int unsigned SCALE_SH  = 8;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 64;

  localparam logic [IDX_W-1:0]     IDX_CAP = IDX_W'(1) << AIDX_W;
  localparam logic signed [CW-1:0] ONE     = CW'(1) <<< FRAC_BITS;
  localparam logic signed [CW-1:0] HALF    = CW'(1) <<< (FRAC_BITS - 1);

  // base-4 digit codes of the curve index
  localparam logic [1:0] DIG_SWAP   = 2'd0;
  localparam logic [1:0] DIG_STEP_X = 2'd1;
  localparam logic [1:0] DIG_DIAG   = 2'd2;
  localparam logic [1:0] DIG_FLIP   = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0]  ox;
    logic signed [CW-1:0]  oy;
    logic signed [CW-1:0]  xi;
    logic signed [CW-1:0]  xj;
    logic signed [CW-1:0]  yi;
    logic signed [CW-1:0]  yj;
    logic [AIDX_W-1:0]     idx;
    logic [LVL_W-1:0]      lvls;
    logic [SAMPLE_W-1:0]   sample;
    logic                  ovf;
  } hcpm_item_t;

  // order register clamped to 1..ORDER_MAX
  function automatic logic [LVL_W-1:0] eff_order(input logic [CFG_W-1:0] raw);
    logic [LVL_W-1:0] o;
    if (raw == '0) begin
      o = LVL_W'(1);
    end else if (raw > CFG_W'(ORDER_MAX)) begin
      o = LVL_W'(ORDER_MAX);
    end else begin
      o = LVL_W'(raw);
    end
    return o;
  endfunction

endpackage

>>> src/hcpm_cell.sv
// One level of the Hilbert walk: consumes the top index digit and updates origin and axes.
module hcpm_cell import hcpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hcpm_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output hcpm_item_t out_item_o
);

  logic       valid_q, valid_d;
  hcpm_item_t item_q, item_d;

  logic signed [CW-1:0] hxi, hxj, hyi, hyj;
  logic [1:0]           dig;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign valid_d     = in_valid_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    item_d = in_item_i;
    hxi    = in_item_i.xi >>> 1;
    hxj    = in_item_i.xj >>> 1;
    hyi    = in_item_i.yi >>> 1;
    hyj    = in_item_i.yj >>> 1;
    dig    = in_item_i.idx[AIDX_W-1 -: 2];
    // cells past the configured depth pass the item through
    if (in_item_i.lvls != '0) begin
      item_d.idx  = in_item_i.idx << 2;
      item_d.lvls = in_item_i.lvls - LVL_W'(1);
      case (dig)
        DIG_SWAP: begin
          item_d.xi = hyi; item_d.xj = hyj;
          item_d.yi = hxi; item_d.yj = hxj;
        end
        DIG_STEP_X: begin
          item_d.ox = in_item_i.ox + hxi;
          item_d.oy = in_item_i.oy + hxj;
          item_d.xi = hxi; item_d.xj = hxj;
          item_d.yi = hyi; item_d.yj = hyj;
        end
        DIG_DIAG: begin
          item_d.ox = in_item_i.ox + hxi + hyi;
          item_d.oy = in_item_i.oy + hxj + hyj;
          item_d.xi = hxi; item_d.xj = hxj;
          item_d.yi = hyi; item_d.yj = hyj;
        end
        default: begin
          item_d.ox = in_item_i.ox + hxi + in_item_i.yi;
          item_d.oy = in_item_i.oy + hxj + in_item_i.yj;
          item_d.xi = -hyi; item_d.xj = -hyj;
          item_d.yi = -hxi; item_d.yj = -hxj;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

>>> src/hcpm_out.sv
// Output stage: cell centre, scaling by 255 and the result register.
module hcpm_out import hcpm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hcpm_item_t             in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [POS_W-1:0]    x_o,
  output logic signed [POS_W-1:0]    z_o,
  output logic signed [SAMPLE_W-1:0] height_o,
  output logic                   ovf_o
);

  logic                       valid_q;
  logic signed [POS_W-1:0]    x_q, x_d, z_q, z_d;
  logic signed [SAMPLE_W-1:0] h_q;
  logic                       ovf_q;

  logic signed [CW-1:0]    cx, cz;
  logic signed [SCL_W-1:0] ex, ez, sx, sz;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    cx = in_item_i.ox + ((in_item_i.xi + in_item_i.yi) >>> 1);
    cz = in_item_i.oy + ((in_item_i.xj + in_item_i.yj) >>> 1);
    ex = SCL_W'(cx);
    ez = SCL_W'(cz);
    // x * 255 = x * 256 - x
    sx = (ex <<< SCALE_SH) - ex;
    sz = (ez <<< SCALE_SH) - ez;
    x_d = in_item_i.ovf ? '0 : sx[POS_W-1:0];
    z_d = in_item_i.ovf ? '0 : sz[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      x_q   <= x_d;
      z_q   <= z_d;
      h_q   <= in_item_i.sample;
      ovf_q <= in_item_i.ovf;
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign z_o         = z_q;
  assign height_o    = h_q;
  assign ovf_o       = ovf_q;

endmodule

>>> src/hilbert_curve_point_mapper.sv
// Hilbert curve point mapper: item counter, row of level cells and output register.
// Path: an accepted request is registered in every level cell in turn and then in the output register.
// Throughput: one item per cycle while m_axis_tready_i is high; the row of level cells is fully pipelined.
// Stalls: each stage holds only while full and blocked, so bubbles collapse.
// Reset: pipeline emptied, item index cleared, curve_order set to 1.
module hilbert_curve_point_mapper import hcpm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,  // [7:0] sample_byte
  input  logic                   s_axis_tlast_i,  // frame_end
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o,  // [24:0] x_position, [49:25] z_position,
                                                  // [57:50] height, [63:58] zero
  output logic                   m_axis_tuser_o   // overflow
);

  logic [CFG_W-1:0] order_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [LVL_W-1:0] ord;
  logic [SHAMT_W-1:0] lim_sh, align_sh;
  logic             ovf, s_acc;

  logic [ORDER_MAX:0] cv, cr;
  hcpm_item_t         head_item;
  hcpm_item_t         ci [ORDER_MAX+1];

  logic signed [POS_W-1:0]    x_pos, z_pos;
  logic signed [SAMPLE_W-1:0] height;

  assign ord      = eff_order(order_q);
  assign lim_sh   = SHAMT_W'(ord) << 1;
  assign align_sh = SHAMT_W'(LVL_W'(ORDER_MAX) - ord) << 1;
  assign ovf      = (idx_q >> lim_sh) != '0;
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    idx_d = idx_q;
    if (s_acc) begin
      if (s_axis_tlast_i) begin
        idx_d = '0;
      end else if (idx_q < IDX_CAP) begin
        idx_d = idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= CFG_W'(1);
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      idx_q <= idx_d;
    end
  end

  // head of the row: unit square, index left-aligned so the top digit sits at the MSBs
  always_comb begin
    head_item.ox     = -HALF;
    head_item.oy     = -HALF;
    head_item.xi     = ONE;
    head_item.xj     = '0;
    head_item.yi     = '0;
    head_item.yj     = ONE;
    head_item.idx    = idx_q[AIDX_W-1:0] << align_sh;
    head_item.lvls   = ovf ? '0 : ord;
    head_item.sample = s_axis_tdata_i[SAMPLE_W-1:0];
    head_item.ovf    = ovf;
  end

  assign ci[0]           = head_item;
  assign cv[0]           = s_axis_tvalid_i;
  assign s_axis_tready_o = cr[0];

  for (genvar k = 0; k < ORDER_MAX; k++) begin : g_cell
    hcpm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (cv[k]),
      .in_ready_o  (cr[k]),
      .in_item_i   (ci[k]),
      .out_valid_o (cv[k+1]),
      .out_ready_i (cr[k+1]),
      .out_item_o  (ci[k+1])
    );
  end

  hcpm_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cv[ORDER_MAX]),
    .in_ready_o  (cr[ORDER_MAX]),
    .in_item_i   (ci[ORDER_MAX]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .x_o         (x_pos),
    .z_o         (z_pos),
    .height_o    (height),
    .ovf_o       (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {
    (TDATA_OUT_W - 2 * POS_W - SAMPLE_W)'(0), height, z_pos, x_pos
  };

`ifndef SYNTHESIS
  a_idx_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_CAP)
    else $error("item index beyond saturation cap");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> (idx_q == '0))
    else $error("index not restarted after frame end");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[2*POS_W-1:0] == '0))
    else $error("positions not zero on overflow");

  a_pass_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && ovf) |-> (head_item.lvls == '0))
    else $error("overflowed item enters the walk");
`endif

endmodule
